@@ hdl/msp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the min stack with pop-to-min.
package msp_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;

	localparam logic [1:0] KIND_PUSH    = 2'd0;
	localparam logic [1:0] KIND_POP     = 2'd1;
	localparam logic [1:0] KIND_POP_MIN = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [DATA_W-1:0] value;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [CNT_W-1:0]         depth;
		logic signed [DATA_W-1:0] top_value;
		logic signed [DATA_W-1:0] min_value;
	} rsp_beat_t;

	typedef struct packed {
		logic [ADDR_W-1:0]        pos;
		logic signed [DATA_W-1:0] value;
	} min_entry_t;

	typedef struct packed {
		logic              v_we;
		logic [ADDR_W-1:0] v_waddr;
		logic [DATA_W-1:0] v_wdata;
		logic              v_re;
		logic [ADDR_W-1:0] v_raddr;
		logic              m_we;
		logic [ADDR_W-1:0] m_waddr;
		min_entry_t        m_wdata;
		logic              m_re;
		logic [ADDR_W-1:0] m_raddr;
	} mem_req_t;

endpackage

@@ hdl/min_stack_pop_to_min.sv @@
`timescale 1ns / 1ps
// Min stack with pop-to-min: top level joining the sequencer and its two memories.
//
// A stack of signed 32-bit values beside a stack of strict new minima, each
// minimum entry holding its position and value in one memory word. Every
// request beat yields one response beat with status, depth, top and minimum.
// A push, a rejected operation or an unknown kind holds the block from the
// accept until the response register is loaded; a pop or pop-to-min also
// passes through a load state, in which the new top and new minimum are read
// from the value and minimum memories. A new request is taken the cycle after
// the response register is loaded, even while that beat still waits for
// rsp_ready. Both memories need no clearing after reset; only entries below
// the counts are used.
module min_stack_pop_to_min (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  msp_pkg::req_beat_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output msp_pkg::rsp_beat_t rsp
);
	import msp_pkg::*;

	mem_req_t            mem;
	logic [DATA_W-1:0]   v_rdata;
	min_entry_t          m_rdata;

	msp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.mem       (mem),
		.v_rdata   (v_rdata),
		.m_rdata   (m_rdata)
	);

	msp_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (mem.v_we),
		.waddr (mem.v_waddr),
		.wdata (mem.v_wdata),
		.re    (mem.v_re),
		.raddr (mem.v_raddr),
		.rdata (v_rdata)
	);

	msp_ram #(
		.WIDTH ($bits(min_entry_t)),
		.DEPTH (STACK_DEPTH)
	) u_min_ram (
		.clk   (clk),
		.we    (mem.m_we),
		.waddr (mem.m_waddr),
		.wdata (mem.m_wdata),
		.re    (mem.m_re),
		.raddr (mem.m_raddr),
		.rdata (m_rdata)
	);

endmodule

@@ hdl/msp_ram.sv @@
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with registered read data.
module msp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/msp_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: counts, cached top and minimum, memory requests and result register.
module msp_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  msp_pkg::req_beat_t       req,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output msp_pkg::rsp_beat_t       rsp,
	output msp_pkg::mem_req_t        mem,
	input  logic [msp_pkg::DATA_W-1:0] v_rdata,
	input  msp_pkg::min_entry_t      m_rdata
);
	import msp_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_LOAD, S_PUT} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         mcnt_q;
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] min_q;
	logic [ADDR_W-1:0]        minpos_q;
	logic [1:0]               status_q;
	logic                     load_min_q;
	logic                     rsp_valid_q;
	rsp_beat_t                rsp_q;

	logic                     accept;
	logic                     load_rsp;
	logic [CNT_W-1:0]         nc;
	logic [CNT_W-1:0]         nmc;
	logic [CNT_W-1:0]         nc_m1;
	logic [CNT_W-1:0]         nmc_m1;
	logic [CNT_W-1:0]         minpos_ext;
	logic [1:0]               nst;
	logic                     push_ok;
	logic                     push_min;
	logic                     load_min;
	logic                     rd;

	assign req_ready  = (state_q == S_IDLE);
	assign accept     = req_valid && req_ready;
	assign load_rsp   = (state_q == S_PUT) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign minpos_ext = CNT_W'(minpos_q);

	always_comb begin
		nc       = cnt_q;
		nmc      = mcnt_q;
		nst      = ST_DONE;
		push_ok  = 1'b0;
		push_min = 1'b0;
		load_min = 1'b0;
		rd       = 1'b0;
		case (req.kind)
			KIND_PUSH: begin
				if (cnt_q == CNT_W'(STACK_DEPTH)) begin
					nst = ST_FULL;
				end else begin
					push_ok = 1'b1;
					nc      = cnt_q + CNT_W'(1);
					if (mcnt_q == '0 || req.value < min_q) begin
						push_min = 1'b1;
						nmc      = mcnt_q + CNT_W'(1);
					end
				end
			end
			KIND_POP: begin
				if (cnt_q == '0) begin
					nst = ST_EMPTY;
				end else begin
					rd = 1'b1;
					nc = cnt_q - CNT_W'(1);
					if (mcnt_q != '0 && minpos_ext >= nc) begin
						nmc      = mcnt_q - CNT_W'(1);
						load_min = 1'b1;
					end
				end
			end
			KIND_POP_MIN: begin
				if (cnt_q == '0 || mcnt_q == '0) begin
					nst = ST_EMPTY;
				end else begin
					rd       = 1'b1;
					nc       = (minpos_ext < cnt_q) ? minpos_ext : cnt_q;
					nmc      = mcnt_q - CNT_W'(1);
					load_min = 1'b1;
				end
			end
			default: begin
			end
		endcase
		nc_m1  = nc - CNT_W'(1);
		nmc_m1 = nmc - CNT_W'(1);

		mem.v_we          = accept && push_ok;
		mem.v_waddr       = cnt_q[ADDR_W-1:0];
		mem.v_wdata       = req.value;
		mem.v_re          = accept && rd;
		mem.v_raddr       = nc_m1[ADDR_W-1:0];
		mem.m_we          = accept && push_min;
		mem.m_waddr       = mcnt_q[ADDR_W-1:0];
		mem.m_wdata.pos   = cnt_q[ADDR_W-1:0];
		mem.m_wdata.value = req.value;
		mem.m_re          = accept && rd;
		mem.m_raddr       = nmc_m1[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			mcnt_q      <= '0;
			top_q       <= '0;
			min_q       <= '0;
			minpos_q    <= '0;
			status_q    <= ST_DONE;
			load_min_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q      <= nc;
						mcnt_q     <= nmc;
						status_q   <= nst;
						load_min_q <= load_min;
						if (push_ok) begin
							top_q <= req.value;
						end
						if (push_min) begin
							min_q    <= req.value;
							minpos_q <= cnt_q[ADDR_W-1:0];
						end
						state_q <= rd ? S_LOAD : S_PUT;
					end
				end
				S_LOAD: begin
					top_q <= (cnt_q != '0) ? $signed(v_rdata) : '0;
					if (load_min_q) begin
						if (mcnt_q != '0) begin
							min_q    <= m_rdata.value;
							minpos_q <= m_rdata.pos;
						end else begin
							min_q <= '0;
						end
					end
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (load_rsp) begin
						rsp_q.status    <= status_q;
						rsp_q.depth     <= cnt_q;
						rsp_q.top_value <= top_q;
						rsp_q.min_value <= min_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/msp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the min stack, bound to the top level.
module msp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input msp_pkg::req_beat_t req,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input msp_pkg::rsp_beat_t rsp
);
	import msp_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat dropped or changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.depth == '0 |-> rsp.top_value == '0 && rsp.min_value == '0)
		else $error("empty stack reports nonzero top or minimum");

	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.depth == CNT_W'(STACK_DEPTH))
		else $error("full status with stack not full");

	a_empty_depth: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.depth == '0)
		else $error("empty status with entries on stack");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.depth <= CNT_W'(STACK_DEPTH))
		else $error("depth beyond stack capacity");

endmodule

bind min_stack_pop_to_min msp_checker u_msp_checker (.*);

@@ tb/msp_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the min stack: predicts each response beat from accepted requests and compares.
module msp_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  msp_pkg::req_beat_t req,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  msp_pkg::rsp_beat_t rsp,
	output int                 errors,
	output int                 pending,
	output int                 checked,
	output int                 peak_depth
);

	import msp_pkg::*;

	logic signed [DATA_W-1:0] stack_vals [STACK_DEPTH];
	logic [ADDR_W-1:0]        min_slots [STACK_DEPTH];
	int unsigned              depth_now = 0;
	int unsigned              mins_now = 0;
	int                       err_count = 0;
	int                       rsp_count = 0;
	int                       depth_high = 0;
	int                       queued = 0;
	rsp_beat_t                expected_rsps [$];

	assign errors     = err_count;
	assign pending    = queued;
	assign checked    = rsp_count;
	assign peak_depth = depth_high;

	function automatic rsp_beat_t apply_stack_op(input req_beat_t op);
		rsp_beat_t         r;
		logic [ADDR_W-1:0] cut;
		r.status = ST_DONE;
		case (op.kind)
			KIND_PUSH: begin
				if (depth_now >= STACK_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					stack_vals[depth_now] = op.value;
					if (mins_now == 0 ||
					    $signed(op.value) < $signed(stack_vals[min_slots[mins_now - 1]])) begin
						min_slots[mins_now] = ADDR_W'(depth_now);
						mins_now++;
					end
					depth_now++;
				end
			end
			KIND_POP: begin
				if (depth_now == 0) begin
					r.status = ST_EMPTY;
				end else begin
					depth_now--;
					if (mins_now > 0 && min_slots[mins_now - 1] >= depth_now)
						mins_now--;
				end
			end
			KIND_POP_MIN: begin
				if (depth_now == 0 || mins_now == 0) begin
					r.status = ST_EMPTY;
				end else begin
					cut = min_slots[mins_now - 1];
					if (cut < depth_now)
						depth_now = cut;
					mins_now--;
				end
			end
			default: begin
			end
		endcase
		if (int'(depth_now) > depth_high)
			depth_high = int'(depth_now);
		r.depth     = CNT_W'(depth_now);
		r.top_value = (depth_now > 0) ? stack_vals[depth_now - 1] : '0;
		r.min_value = (mins_now > 0) ? stack_vals[min_slots[mins_now - 1]] : '0;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [DATA_W-1:0] want_f,
	                           input logic [DATA_W-1:0] got_f);
		if (got_f !== want_f) begin
			err_count++;
			$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want_f, got_f);
		end
	endtask

	always @(posedge clk) begin
		rsp_beat_t want;
		if (arst_n) begin
			if (req_valid && req_ready)
				expected_rsps = {expected_rsps, apply_stack_op(req)};
			if (rsp_valid && rsp_ready) begin
				rsp_count++;
				if (expected_rsps.size() == 0) begin
					err_count++;
					$display("%0t: response beat expected none actual status %0d depth %0d",
					         $time, rsp.status, rsp.depth);
				end else begin
					want = expected_rsps.pop_front();
					check_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
					check_field("depth", DATA_W'(want.depth), DATA_W'(rsp.depth));
					check_field("top_value", want.top_value, rsp.top_value);
					check_field("min_value", want.min_value, rsp.min_value);
				end
			end
			queued = expected_rsps.size();
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the min stack: clock, reset, request and response drivers, verdict.
module tb;

	import msp_pkg::*;

	localparam logic [1:0]               KIND_NONE   = 2'd3;
	localparam logic signed [DATA_W-1:0] VAL_MAX     = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] VAL_MIN     = 32'sh8000_0000;
	localparam int                       RANDOM_OPS  = 380;
	localparam int                       QUIET_OPS   = 80;
	localparam int                       HOLD_CYCLES = 300;
	localparam int                       TAIL_CYCLES = 10;
	localparam int                       CYCLE_LIMIT = 200000;

	logic      clk;
	logic      arst_n;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_beat_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_beat_t rsp;

	int                       error_count;
	int                       pending;
	int                       checked;
	int                       peak_depth;
	int                       ops_sent = 0;
	int                       cycles = 0;
	bit                       quiet = 1'b0;
	bit                       hold_req = 1'b0;
	logic signed [DATA_W-1:0] low_mark = '0;

	min_stack_pop_to_min u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	msp_scoreboard u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.errors     (error_count),
		.pending    (pending),
		.checked    (checked),
		.peak_depth (peak_depth)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return $urandom_range(0, 16) - 8;
			7: begin
				case ($urandom_range(0, 3))
					0:       return VAL_MAX;
					1:       return VAL_MIN;
					2:       return '0;
					default: return -1;
				endcase
			end
			default: begin
				low_mark = low_mark - $urandom_range(1, 1000);
				return low_mark;
			end
		endcase
	endfunction

	task automatic send_op(input logic [1:0] k, input logic signed [DATA_W-1:0] v);
		req_beat_t beat;
		beat.kind  = k;
		beat.value = v;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= beat;
		do @(posedge clk); while (!req_ready);
		ops_sent++;
	endtask

	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall    = HOLD_CYCLES;
			end else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 4);
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				stall--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned roll;
		@(posedge arst_n);
		@(posedge clk);

		send_op(KIND_POP, '0);
		send_op(KIND_POP_MIN, '0);
		send_op(KIND_NONE, VAL_MAX);
		send_op(KIND_PUSH, VAL_MAX);
		send_op(KIND_PUSH, '0);
		send_op(KIND_PUSH, '0);
		send_op(KIND_PUSH, -1);
		send_op(KIND_PUSH, VAL_MIN);
		send_op(KIND_PUSH, -5);
		send_op(KIND_PUSH, VAL_MIN);
		send_op(KIND_NONE, -1);
		send_op(KIND_POP, '0);
		send_op(KIND_POP, '0);
		send_op(KIND_POP_MIN, '0);
		send_op(KIND_POP, '0);
		send_op(KIND_POP_MIN, '0);
		send_op(KIND_PUSH, VAL_MAX);
		send_op(KIND_POP_MIN, '0);
		send_op(KIND_POP_MIN, '0);
		send_op(KIND_PUSH, -1);
		send_op(KIND_POP, '0);

		hold_req = 1'b1;
		low_mark = '0;
		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (i == RANDOM_OPS - QUIET_OPS)
				quiet = 1'b1;
			roll = $urandom_range(0, 19);
			if (roll < 11)
				send_op(KIND_PUSH, pick_value());
			else if (roll < 15)
				send_op(KIND_POP, $urandom);
			else if (roll < 19)
				send_op(KIND_POP_MIN, $urandom);
			else
				send_op(KIND_NONE, $urandom);
		end
		req_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb: %0d operations sent over directed corner cases and a random mix", ops_sent);
		$display("tb: %0d results checked, peak stack depth %0d of %0d", checked, peak_depth,
		         STACK_DEPTH);
		if (error_count == 0 && pending == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
